@@ rtl/usbsx_pkg.sv @@
// ----------------------------------------------------------------------------
// usbsx_pkg
// shared types and constants for the usb-midi sysex reassembler
// ----------------------------------------------------------------------------
package usbsx_pkg;

   // default depth of the payload store
   localparam int DEF_BUF_DEPTH = 32;

   // midi sysex framing bytes
   localparam logic [7:0] SX_START = 8'hF0;
   localparam logic [7:0] SX_END   = 8'hF7;

   // reset value of the header id register
   localparam logic [6:0] HDR_ID_RESET = 7'h7D;

   // usb-midi code indices that carry sysex
   localparam logic [3:0] CIN_SX_CONT = 4'h4;
   localparam logic [3:0] CIN_SX_END1 = 4'h5;
   localparam logic [3:0] CIN_SX_END2 = 4'h6;
   localparam logic [3:0] CIN_SX_END3 = 4'h7;

   // one usb-midi event packet
   typedef struct packed {
      logic [7:0] code_index;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
   } req_type;

   // one payload byte of a finished message
   typedef struct packed {
      logic [7:0] payload_byte;
      logic [4:0] byte_position;
      logic [5:0] message_length;
      logic       last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch a new packet
      logic step;       // apply the current byte (not a closing end)
      logic close;      // close the open message, rewind read pointer
      logic next_byte;  // move to the next carried byte
      logic rd_issue;   // read the store at the read pointer
      logic rd_next;    // advance the read pointer
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_sysex;    // incoming packet carries sysex bytes
      logic end_hit;      // current byte closes an open message
      logic last_byte;    // current byte is the packet's last one
      logic last_result;  // result on show is the burst's final one
   } sts_type;

endpackage

@@ rtl/usbsx_dp.sv @@
// ----------------------------------------------------------------------------
// usbsx_dp
// packet latch, message state, payload store and result register
// ----------------------------------------------------------------------------
module usbsx_dp #(
   parameter int BUF_DEPTH = usbsx_pkg::DEF_BUF_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  usbsx_pkg::req_type req_data,
   output usbsx_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [6:0]         csr_data,
   input  usbsx_pkg::cmd_type cmd,
   output usbsx_pkg::sts_type sts
);
   import usbsx_pkg::*;

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CW = $clog2(BUF_DEPTH + 1);

   logic          in_msg_ff, in_msg_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [1:0]    idx_ff, idx_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [AW-1:0] rd_cnt_ff, rd_cnt_in;
   logic [6:0]    hdr_ff, hdr_in;
   logic [7:0]    b0_ff, b1_ff, b2_ff;
   logic [7:0]    rd_data_ff;
   logic [7:0]    mem [BUF_DEPTH];

   logic [1:0]    req_cnt;
   logic [7:0]    cur_byte;
   logic          is_hdr;
   logic          wr_en;

   // bytes carried per code index, zero for anything but sysex
   always_comb begin
      case (req_data.code_index[3:0])
         CIN_SX_END1: req_cnt = 2'd1;
         CIN_SX_END2: req_cnt = 2'd2;
         CIN_SX_CONT,
         CIN_SX_END3: req_cnt = 2'd3;
         default:     req_cnt = 2'd0;
      endcase
   end

   always_comb begin
      case (idx_ff)
         2'd0:    cur_byte = b0_ff;
         2'd1:    cur_byte = b1_ff;
         default: cur_byte = b2_ff;
      endcase
   end

   assign is_hdr = (fill_ff == '0) && (cur_byte == {1'b0, hdr_ff});
   assign wr_en  = cmd.step && in_msg_ff && (cur_byte != SX_START) &&
                   (cur_byte != SX_END) && !is_hdr && (fill_ff < CW'(BUF_DEPTH));

   assign sts.req_sysex   = (req_cnt != 2'd0);
   assign sts.end_hit     = in_msg_ff && (cur_byte == SX_END);
   assign sts.last_byte   = ((idx_ff + 2'd1) == cnt_ff);
   assign sts.last_result = (fill_ff == '0) || ((CW'(rd_cnt_ff) + CW'(1)) == fill_ff);

   always_comb begin
      in_msg_in = in_msg_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      rd_cnt_in = rd_cnt_ff;
      hdr_in    = csr_we ? csr_data : hdr_ff;
      if (cmd.load) begin
         idx_in = 2'd0;
         cnt_in = req_cnt;
      end
      if (cmd.next_byte) begin
         idx_in = idx_ff + 2'd1;
      end
      if (cmd.step && (cur_byte == SX_START)) begin
         in_msg_in = 1'b1;
         fill_in   = '0;
      end else if (wr_en) begin
         fill_in = fill_ff + CW'(1);
      end
      if (cmd.close) begin
         in_msg_in = 1'b0;
         rd_cnt_in = '0;
      end
      if (cmd.rd_next) begin
         rd_cnt_in = rd_cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         fill_ff   <= '0;
         idx_ff    <= 2'd0;
         cnt_ff    <= 2'd0;
         rd_cnt_ff <= '0;
         hdr_ff    <= HDR_ID_RESET;
      end else begin
         in_msg_ff <= in_msg_in;
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
         cnt_ff    <= cnt_in;
         rd_cnt_ff <= rd_cnt_in;
         hdr_ff    <= hdr_in;
      end
   end

   // packet bytes, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         b0_ff <= req_data.first_byte;
         b1_ff <= req_data.second_byte;
         b2_ff <= req_data.third_byte;
      end
   end

   // payload store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[AW-1:0]] <= cur_byte;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[rd_cnt_ff];
      end
   end

   // empty message shows zero in every field but last
   assign rsp_data.payload_byte   = (fill_ff == '0) ? 8'h00 : rd_data_ff;
   assign rsp_data.byte_position  = 5'(rd_cnt_ff);
   assign rsp_data.message_length = 6'(fill_ff);
   assign rsp_data.last           = sts.last_result;

endmodule

@@ rtl/usbsx_ctrl.sv @@
// ----------------------------------------------------------------------------
// usbsx_ctrl
// sequencer: packet accept, byte walk and burst drain
// ----------------------------------------------------------------------------
module usbsx_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  usbsx_pkg::sts_type sts,
   output usbsx_pkg::cmd_type cmd
);
   import usbsx_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_BYTE = 4'b0010,
      ST_READ = 4'b0100,
      ST_SHOW = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.req_sysex) begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_BYTE: begin
            if (sts.end_hit) begin
               cmd.close = 1'b1;
               state_in  = ST_READ;
            end else begin
               cmd.step = 1'b1;
               if (sts.last_byte) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_byte = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_SHOW;
         end
         ST_SHOW: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (sts.last_result) begin
                  if (sts.last_byte) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.next_byte = 1'b1;
                     state_in      = ST_BYTE;
                  end
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/usb_midi_sysex_reassembler.sv @@
// ----------------------------------------------------------------------------
// usb_midi_sysex_reassembler
// rebuilds sysex messages from usb-midi event packets
// ----------------------------------------------------------------------------
// Takes one 4-byte usb-midi event packet per req word and walks its sysex
// bytes (code index 4 to 7, cable number ignored) one per cycle while no
// burst is draining. 0xF0 opens a message, 0xF7 closes it and the stored
// payload comes out as a burst of rsp words with last set on the final one;
// an empty message gives a single word of length zero. A header byte equal
// to the csr value while no payload is stored yet is dropped, and bytes past
// BUF_DEPTH are discarded. A packet is taken only while idle, and req_stall
// holds the next one until all its bytes are walked; each result word of a
// burst is read from the store and then shown, and is held while rsp_stall
// is high, as the store has a single registered read port. The store needs
// no clearing after reset. csr writes are always ready and
// must only be made while the block is idle.
// ----------------------------------------------------------------------------
module usb_midi_sysex_reassembler #(
   parameter int BUF_DEPTH = usbsx_pkg::DEF_BUF_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   // packet input
   input  logic               req_valid,
   output logic               req_stall,
   input  usbsx_pkg::req_type req_data,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output usbsx_pkg::rsp_type rsp_data,
   // header id register write
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_data
);
   import usbsx_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register write never waits
   assign csr_ready = 1'b1;

   // sequencer
   usbsx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // message state, payload store and result fields
   usbsx_dp #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .csr_we   (csr_valid & csr_ready),
      .csr_data (csr_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the usb-midi sysex reassembler
// ----------------------------------------------------------------------------
// Feeds usb-midi event packets through the req channel, first from a short
// table of hand-picked packets, then as random streams of sysex messages cut
// into packets with noise and broken framing mixed in. A behavioral model of
// the reassembly runs beside the block and queues the rsp words each packet
// should release; every rsp word taken is checked field by field against the
// oldest queued one. The header id register is rewritten between phases
// while the block is idle, covering both extremes.
// ----------------------------------------------------------------------------
module tb;
   import usbsx_pkg::*;

   localparam int BUF_DEPTH       = DEF_BUF_DEPTH;
   localparam int IDLE_TAIL       = 8;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int PREDICTED       = -1;    // row has no hand-written result
   localparam logic [6:0] HDR_MIN = 7'h00;
   localparam logic [6:0] HDR_MAX = 7'h7F;

   // code indices that carry no sysex
   localparam logic [3:0] CIN_MISC     = 4'h0;
   localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
   localparam logic [3:0] CIN_SINGLE   = 4'hF;

   // the single word an empty message gives
   localparam rsp_type EMPTY_WORD = {8'h00, 5'd0, 6'd0, 1'b1};

   typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_HEAVY, STALL_RUNS} stall_mode_type;

   typedef struct {
      req_type pkt;
      int      reps;
      int      n_typed;
      rsp_type typed;
   } stim_row_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data  = '0;

   // model of the reassembly state
   logic [6:0] hdr_model = HDR_ID_RESET;
   logic       msg_open  = 1'b0;
   int         fill      = 0;
   logic [7:0] payload_mem [BUF_DEPTH];

   rsp_type       due_words[$];     // words the block still owes, oldest first
   rsp_type       fresh_words[$];   // words released by the packet just taken
   stim_row_type  directed_rows[$];
   int            faults      = 0;
   int            sysex_sent  = 0;
   int            burst_left  = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   usb_midi_sysex_reassembler #(
      .BUF_DEPTH (BUF_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // model
   // ---------------------------------------------------------------------

   // one midi byte through the framing logic; closes append to fresh_words
   function automatic void absorb_byte(input logic [7:0] b);
      int k;
      if (b == SX_START) begin
         msg_open = 1'b1;
         fill     = 0;
      end else if (b == SX_END && msg_open) begin
         msg_open = 1'b0;
         if (fill == 0) begin
            fresh_words.push_back(EMPTY_WORD);
         end else begin
            for (k = 0; k < fill; k++)
               fresh_words.push_back({payload_mem[k], 5'(k), 6'(fill), k == fill - 1});
         end
      end else if (msg_open) begin
         // manufacturer id is swallowed while nothing is stored yet
         if (fill == 0 && b == {1'b0, hdr_model}) begin
         end else if (fill < BUF_DEPTH) begin
            payload_mem[fill] = b;
            fill++;
         end
      end
   endfunction

   function automatic void reassemble_packet(input req_type p);
      int n;
      case (p.code_index[3:0])
         CIN_SX_END1: n = 1;
         CIN_SX_END2: n = 2;
         CIN_SX_CONT, CIN_SX_END3: n = 3;
         default: n = 0;   // cable number and non-sysex indices ignored
      endcase
      if (n > 0) absorb_byte(p.first_byte);
      if (n > 1) absorb_byte(p.second_byte);
      if (n > 2) absorb_byte(p.third_byte);
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   task automatic add_row(input logic [3:0] cable, input logic [3:0] cin,
                          input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                          input int reps, input int n_typed, input rsp_type typed);
      stim_row_type row;
      row.pkt     = {cable, cin, b0, b1, b2};
      row.reps    = reps;
      row.n_typed = n_typed;
      row.typed   = typed;
      directed_rows.push_back(row);
   endtask

   // offer one packet, wait for it to be taken, then queue what it releases
   task automatic post_packet(input req_type pkt, input int n_typed, input rsp_type typed);
      int gap;
      int i;
      if (burst_left == 0) begin
         // a quarter of the bursts run straight into the next one
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= pkt;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      // taken at this edge
      fresh_words.delete();
      reassemble_packet(pkt);
      if (n_typed == PREDICTED) begin
         for (i = 0; i < fresh_words.size(); i++) due_words.push_back(fresh_words[i]);
      end else begin
         repeat (n_typed) due_words.push_back(typed);
      end
      if (pkt.code_index[3:0] inside {CIN_SX_CONT, CIN_SX_END1, CIN_SX_END2, CIN_SX_END3})
         sysex_sent++;
   endtask

   // hold the sender until the block owes nothing and has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (due_words.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic write_header(input logic [6:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      hdr_model = value;
      csr_valid <= 1'b0;
   endtask

   // mostly plain data, some status bytes, now and then anything at all
   function automatic logic [7:0] pick_byte();
      logic [7:0] v;
      int r;
      r = $urandom_range(0, 19);
      if (r < 16) begin
         v = 8'($urandom_range(0, 127));
      end else if (r < 19) begin
         v = 8'($urandom_range(128, 255));
         if (v == SX_START || v == SX_END) v ^= 8'h01;
      end else begin
         v = 8'($urandom);
      end
      return v;
   endfunction

   // one to three messages or runs of stray bytes as a byte stream, cut into packets at random
   task automatic play_stream();
      logic [7:0] stream[$];
      logic [7:0] b[3];
      logic [3:0] cin;
      req_type    pkt;
      int         kind;
      int         len;
      int         r;
      int         c;
      int         i;
      repeat ($urandom_range(1, 3)) begin
         kind = $urandom_range(0, 9);
         if (kind < 9) begin
            stream.push_back(SX_START);
            if ($urandom_range(0, 2) == 0) stream.push_back({1'b0, hdr_model});
            r   = $urandom_range(0, 19);
            len = (r < 16) ? $urandom_range(0, 12) :
                  (r < 19) ? $urandom_range(13, 31) : $urandom_range(32, 40);
            repeat (len) stream.push_back(pick_byte());
            // one in nine is left unterminated
            if (kind < 8) stream.push_back(SX_END);
         end else begin
            // stray ends and loose bytes
            repeat ($urandom_range(1, 4))
               stream.push_back($urandom_range(0, 1) ? SX_END : 8'($urandom));
         end
      end
      while (stream.size() != 0) begin
         if ($urandom_range(0, 9) == 0) post_packet(req_type'($urandom), PREDICTED, '0);
         r = $urandom_range(0, 19);
         c = (r < 14) ? 3 : (r < 17) ? 2 : 1;
         if (c > stream.size()) c = stream.size();
         for (i = 0; i < 3; i++) b[i] = (i < c) ? stream.pop_front() : 8'($urandom);
         cin = (c == 3) ? ($urandom_range(0, 1) ? CIN_SX_CONT : CIN_SX_END3) :
               (c == 2) ? CIN_SX_END2 : CIN_SX_END1;
         pkt = {4'($urandom), cin, b[0], b[1], b[2]};
         post_packet(pkt, PREDICTED, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver stalls in randomly switched patterns
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
         default:      rsp_stall <= (stall_left[3:0] < 4'd6);   // stalls in runs set by the countdown
      endcase
   end

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (due_words.size() == 0) begin
            $error("rsp word %h with nothing outstanding", rsp_data);
            faults++;
         end else begin
            want = due_words.pop_front();
            check_field("payload_byte", int'(want.payload_byte),
                        int'(rsp_data.payload_byte));
            check_field("byte_position", int'(want.byte_position),
                        int'(rsp_data.byte_position));
            check_field("message_length", int'(want.message_length),
                        int'(rsp_data.message_length));
            check_field("last", int'(want.last), int'(rsp_data.last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [6:0] hdr;
      int phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // hand-picked packets; header id still at its reset value
      // stray end right after reset
      add_row(4'h0, CIN_SX_END1, SX_END, 8'h00, 8'h00, 1, 0, '0);
      // empty message
      add_row(4'h0, CIN_SX_END2, SX_START, SX_END, 8'h00, 1, 1, EMPTY_WORD);
      // reset header id dropped, leaving the message empty
      add_row(4'h0, CIN_SX_END3, SX_START, 8'h7D, SX_END, 1, 1, EMPTY_WORD);
      // one-byte message
      add_row(4'h0, CIN_SX_END3, SX_START, 8'h41, SX_END, 1, 1, {8'h41, 5'd0, 6'd1, 1'b1});
      // header dropped while nothing is stored yet, so the second copy goes too
      add_row(4'h9, CIN_SX_CONT, SX_START, 8'h7D, 8'h7D, 1, 0, '0);
      add_row(4'h0, CIN_SX_END3, 8'h00, 8'hFF, SX_END, 1, PREDICTED, '0);
      // non-sysex code indices leave everything alone
      add_row(4'h0, CIN_MISC, SX_START, 8'h11, SX_END, 1, 0, '0);
      add_row(4'hF, CIN_NOTE_OFF, SX_END, SX_START, SX_END, 1, 0, '0);
      add_row(4'hA, CIN_SINGLE, SX_END, 8'hFF, 8'hFF, 1, 0, '0);
      // bytes outside any message
      add_row(4'h0, CIN_SX_END1, 8'h12, 8'h34, 8'h56, 1, 0, '0);
      // restart drops the first payload
      add_row(4'h0, CIN_SX_CONT, SX_START, 8'h11, 8'h22, 1, 0, '0);
      add_row(4'h3, CIN_SX_CONT, SX_START, 8'h33, 8'h44, 1, 0, '0);
      // status byte stored as payload
      add_row(4'h0, CIN_SX_END2, 8'h80, SX_END, 8'hAA, 1, PREDICTED, '0);
      // close, reopen and close again inside one packet
      add_row(4'h5, CIN_SX_CONT, SX_START, 8'h55, 8'h66, 1, 0, '0);
      add_row(4'h0, CIN_SX_END3, SX_END, SX_START, SX_END, 1, PREDICTED, '0);
      // overflow: 36 bytes offered, store keeps the first 32
      add_row(4'h0, CIN_SX_END1, SX_START, 8'h00, 8'h00, 1, 0, '0);
      add_row(4'hC, CIN_SX_CONT, 8'hA5, 8'h5A, 8'hC3, 12, 0, '0);
      add_row(4'h0, CIN_SX_END1, SX_END, 8'h00, 8'h00, 1, PREDICTED, '0);
      // extreme data values
      add_row(4'hF, CIN_SX_CONT, SX_START, 8'hFF, 8'h00, 1, 0, '0);
      add_row(4'h0, CIN_SX_END3, 8'hFE, 8'h01, SX_END, 1, PREDICTED, '0);

      foreach (directed_rows[i])
         repeat (directed_rows[i].reps)
            post_packet(directed_rows[i].pkt, directed_rows[i].n_typed, directed_rows[i].typed);

      // random streams, one header id setting per phase
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       hdr = HDR_MIN;
            1:       hdr = HDR_MAX;
            2:       hdr = 7'($urandom_range(1, 126));
            default: hdr = HDR_ID_RESET;
         endcase
         write_header(hdr);
         sysex_sent = 0;
         while (sysex_sent < ITEMS_PER_PHASE) play_stream();
      end

      settle();
      if (faults == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
